>>> design/sliding_window_median_top_defines.svh
// Assertion macros shared by the sliding window median filter RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/swm_pkg.sv
// Shared types and constants of the sliding window median filter.
// No dependencies; used by swm_cell and sliding_window_median_top.
package swm_pkg;

	localparam int WS_WIDTH   = 5;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [WS_WIDTH-1:0] WS_RESET = 5'd3;

	// Register index as decoded from paddr[2]
	localparam logic REG_WINDOW_SIZE = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_SHRINK
	} state_t;

	// Per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic en;      // update the cell this cycle
		logic clr;     // treat the row as empty before the update
		logic del_en;  // remove the entry whose age matches del_age
		logic ins_en;  // insert the new sample in sorted position
	} cell_ctl_t;

endpackage

>>> design/swm_cell.sv
// One cell of the sorted sample row: holds a value, its age and a valid bit.
// Depends on swm_pkg for the cell command struct.
module swm_cell #(
	parameter int SW  = 16,
	parameter int AW  = 4,
	parameter int FW  = 5,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swm_pkg::cell_ctl_t    ctl,
	input  logic [AW-1:0]         del_age,
	input  logic signed [SW-1:0]  smp,
	input  logic [FW-1:0]         lo_pos,
	input  logic [FW-1:0]         hi_pos,
	// current contents of the cell above
	input  logic signed [SW-1:0]  up_v,
	input  logic [AW-1:0]         up_a,
	input  logic                  up_vld,
	// compacted contents of the cell below
	input  logic signed [SW-1:0]  dn_v,
	input  logic [AW-1:0]         dn_a,
	input  logic                  dn_vld,
	input  logic                  dn_gt,
	input  logic                  del_in,
	input  logic signed [SW-1:0]  med_lo_in,
	input  logic signed [SW-1:0]  med_hi_in,
	output logic signed [SW-1:0]  cur_v,
	output logic [AW-1:0]         cur_a,
	output logic                  cur_vld,
	output logic                  held,
	output logic signed [SW-1:0]  nx_v,
	output logic [AW-1:0]         nx_a,
	output logic                  nx_vld,
	output logic                  nx_gt,
	output logic                  del_out,
	output logic signed [SW-1:0]  med_lo_out,
	output logic signed [SW-1:0]  med_hi_out
);
	import swm_pkg::*;

	logic signed [SW-1:0] v_q;
	logic [AW-1:0]        a_q;
	logic                 vld_q;
	logic signed [SW-1:0] v_d;
	logic [AW-1:0]        a_d;
	logic                 vld_d;
	logic                 hit;

	assign cur_v   = v_q;
	assign cur_a   = a_q;
	assign cur_vld = vld_q && !ctl.clr;
	assign held    = vld_q;

	// Removal ripples upward: every cell at or above the removed entry pulls from above
	assign hit     = ctl.del_en && cur_vld && (a_q == del_age);
	assign del_out = del_in || hit;

	always_comb begin
		if (del_out) begin
			nx_v   = up_v;
			nx_a   = up_a;
			nx_vld = up_vld;
		end else begin
			nx_v   = v_q;
			nx_a   = a_q;
			nx_vld = cur_vld;
		end
	end

	assign nx_gt = !nx_vld || (nx_v > smp);

	always_comb begin
		v_d   = nx_v;
		a_d   = nx_a;
		vld_d = nx_vld;
		if (ctl.ins_en) begin
			if (!nx_gt) begin
				a_d = nx_a + AW'(1);
			end else if (!dn_gt) begin
				v_d   = smp;
				a_d   = '0;
				vld_d = 1'b1;
			end else begin
				v_d   = dn_v;
				a_d   = dn_a + AW'(1);
				vld_d = dn_vld;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			v_q <= v_d;
			a_q <= a_d;
		end
	end

	// Median taps: the cell at a middle rank contributes its value to the chain
	assign med_lo_out = med_lo_in | ((FW'(IDX) == lo_pos) ? v_q : '0);
	assign med_hi_out = med_hi_in | ((FW'(IDX) == hi_pos) ? v_q : '0);

endmodule

>>> design/sliding_window_median_top.sv
// Sliding window median filter. Samples arrive on the s_ stream, results leave on the
// m_ stream; one result follows each sample once the window holds window_size samples.
// The window is kept as a row of MAX_WINDOW cells in sorted order, each cell carrying the
// sample's age, so a single update removes the oldest sample and inserts the new one. In
// steady state a sample is accepted without delay, also when start is flagged, unless the
// output stalls; after window_size has been lowered, the first sample is held while
// the row drops one entry per cycle until it fits. The result is loaded into the output
// register once the cells have updated and it is free, from an OR chain over the
// middle-rank cells and one add. window_size 0 acts as 1, above MAX_WINDOW as MAX_WINDOW.
`include "sliding_window_median_top_defines.svh"

module sliding_window_median_top #(
	parameter int MAX_WINDOW   = 16,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_WIDTH-1:0] sample
	input  logic [0:0]                            s_tuser,   // [0] start_req
	// master stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_WIDTH+8)/8)*8-1:0]     m_tdata,   // [SAMPLE_WIDTH:0] median_twice
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [swm_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [swm_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [swm_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                  pready
);
	import swm_pkg::*;

	localparam int SW  = SAMPLE_WIDTH;
	localparam int ODW = ((SAMPLE_WIDTH + 8) / 8) * 8;
	localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FW  = $clog2(MAX_WINDOW + 1);

	// Configuration
	logic [WS_WIDTH-1:0] ws_q;
	logic [FW-1:0]       weff;
	logic [FW-1:0]       lo_pos;
	logic [FW-1:0]       hi_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE) begin
			ws_q <= pwdata[WS_WIDTH-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? CFG_DATA_W'(ws_q) : '0;

	always_comb begin
		if (ws_q == '0) begin
			weff = FW'(1);
		end else if (32'(ws_q) > MAX_WINDOW) begin
			weff = FW'(MAX_WINDOW);
		end else begin
			weff = FW'(ws_q);
		end
	end

	assign lo_pos = (weff - FW'(1)) >> 1;
	assign hi_pos = weff >> 1;

	// Control
	state_t               st_q;
	state_t               st_d;
	logic [FW-1:0]        fill_q;
	logic [FW-1:0]        fill_eff;
	logic [FW-1:0]        fill_new;
	logic                 pend_q;
	logic                 o_load;
	logic                 accept;
	logic signed [SW-1:0] smp_q;
	logic signed [SW-1:0] smp;
	cell_ctl_t            ctl;
	logic [AW-1:0]        del_age;
	logic                 o_vld_q;
	logic [SW:0]          o_data_q;

	assign o_load   = pend_q && (!o_vld_q || m_tready);
	assign s_tready = (st_q == ST_IDLE) && (!pend_q || o_load);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		st_d = st_q;
		ctl  = '0;
		unique case (st_q)
			ST_IDLE: begin
				ctl.en   = accept;
				ctl.clr  = accept && s_tuser[0];
				fill_eff = ctl.clr ? '0 : fill_q;
				smp      = s_tdata[SW-1:0];
			end
			ST_SHRINK: begin
				ctl.en   = 1'b1;
				fill_eff = fill_q;
				smp      = smp_q;
			end
			default: begin
				fill_eff = fill_q;
				smp      = smp_q;
			end
		endcase
		ctl.del_en = fill_eff >= weff;
		ctl.ins_en = fill_eff <= weff;
		del_age    = AW'(fill_eff - FW'(1));
		fill_new   = fill_eff - FW'(ctl.del_en) + FW'(ctl.ins_en);
		// Drop one excess sample per cycle until the row fits the window
		if (ctl.en) begin
			st_d = ctl.ins_en ? ST_IDLE : ST_SHRINK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			fill_q <= '0;
			pend_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ctl.en) begin
				fill_q <= fill_new;
			end
			if (ctl.en && ctl.ins_en && fill_new == weff) begin
				pend_q <= 1'b1;
			end else if (o_load) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= s_tdata[SW-1:0];
		end
	end

	// Cell row
	logic signed [SW-1:0] c_v     [MAX_WINDOW+1];
	logic [AW-1:0]        c_a     [MAX_WINDOW+1];
	logic                 c_vld   [MAX_WINDOW+1];
	logic signed [SW-1:0] n_v     [MAX_WINDOW+1];
	logic [AW-1:0]        n_a     [MAX_WINDOW+1];
	logic                 n_vld   [MAX_WINDOW+1];
	logic                 n_gt    [MAX_WINDOW+1];
	logic                 del_c   [MAX_WINDOW+1];
	logic signed [SW-1:0] med_lo  [MAX_WINDOW+1];
	logic signed [SW-1:0] med_hi  [MAX_WINDOW+1];
	logic [MAX_WINDOW-1:0] held_vec;

	assign c_v[MAX_WINDOW]   = '0;
	assign c_a[MAX_WINDOW]   = '0;
	assign c_vld[MAX_WINDOW] = 1'b0;
	assign n_v[0]            = '0;
	assign n_a[0]            = '0;
	assign n_vld[0]          = 1'b0;
	assign n_gt[0]           = 1'b0;
	assign del_c[0]          = 1'b0;
	assign med_lo[0]         = '0;
	assign med_hi[0]         = '0;

	for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
		swm_cell #(
			.SW  (SW),
			.AW  (AW),
			.FW  (FW),
			.IDX (gi)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.del_age    (del_age),
			.smp        (smp),
			.lo_pos     (lo_pos),
			.hi_pos     (hi_pos),
			.up_v       (c_v[gi+1]),
			.up_a       (c_a[gi+1]),
			.up_vld     (c_vld[gi+1]),
			.dn_v       (n_v[gi]),
			.dn_a       (n_a[gi]),
			.dn_vld     (n_vld[gi]),
			.dn_gt      (n_gt[gi]),
			.del_in     (del_c[gi]),
			.med_lo_in  (med_lo[gi]),
			.med_hi_in  (med_hi[gi]),
			.cur_v      (c_v[gi]),
			.cur_a      (c_a[gi]),
			.cur_vld    (c_vld[gi]),
			.held       (held_vec[gi]),
			.nx_v       (n_v[gi+1]),
			.nx_a       (n_a[gi+1]),
			.nx_vld     (n_vld[gi+1]),
			.nx_gt      (n_gt[gi+1]),
			.del_out    (del_c[gi+1]),
			.med_lo_out (med_lo[gi+1]),
			.med_hi_out (med_hi[gi+1])
		);
	end

	// Output register
	logic signed [SW:0] med_sum;

	assign med_sum = {med_lo[MAX_WINDOW][SW-1], med_lo[MAX_WINDOW]}
		+ {med_hi[MAX_WINDOW][SW-1], med_hi[MAX_WINDOW]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
		end else if (o_load) begin
			o_vld_q <= 1'b1;
		end else if (m_tready) begin
			o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			o_data_q <= med_sum;
		end
	end

	assign m_tvalid = o_vld_q;
	assign m_tdata  = ODW'(o_data_q);

	`SWM_ASSERT_NOW(a_pend_full, pend_q, fill_q == weff, "median pending with window not full")
	`SWM_ASSERT_NOW(a_fill_cells, 1'b1, $countones(held_vec) == 32'(fill_q), "fill count and cells disagree")
	`SWM_ASSERT_NEXT(a_shrink_drop, st_q == ST_SHRINK && fill_q > weff, fill_q == $past(fill_q) - FW'(1), "shrink step did not drop one sample")

endmodule
